FILE: design/lap_pkg.sv
// shared types and constants for the laplacian 3x3 rgb filter
// register map, post-processing mode codes and the structs passed between modules
// no dependencies
package lap_pkg;

   // configuration port
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int REG_IDX_W   = 2;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_MODE   = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd2;

   // post-processing modes
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_TRUNC  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CENTER = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MAG    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SCALE  = 2'd3;

   // geometry registers
   localparam int WIDTH_REG_W = 12;
   localparam int HEIGHT_W    = 16;
   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 12'd2048;
   localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = 16'd1;

   // red in [7:0], green in [15:8], blue in [23:16]
   localparam int PIXEL_W = 24;
   typedef logic [PIXEL_W-1:0] pixel_type;

   // register values seen by the datapath
   typedef struct packed {
      logic [MODE_W-1:0]      mode;
      logic [WIDTH_REG_W-1:0] width;
      logic [HEIGHT_W-1:0]    height;
      logic                   restart;
   } cfg_type;

   // neighbourhood of one result pixel
   typedef struct packed {
      logic      border;
      logic      last;
      pixel_type center;
      pixel_type north;
      pixel_type west;
      pixel_type east;
      pixel_type south;
   } taps_type;

   // one result transaction
   typedef struct packed {
      logic      last;
      pixel_type pixel;
   } result_type;

endpackage

FILE: design/laplacian_3x3_rgb_filter.sv
// laplacian 3x3 rgb filter top level: position counters, line stores, window, output queue
// throughput one pixel per clock while req_stall is low; each line store takes one read and
// one write per pixel; a result leaves width+1 pixels after its own pixel; once due, it is
// registered in the line store and kernel stages; flush transactions drain the frame tail at
// one per clock while req_stall is low; synchronous reset clears counters, pipeline and queue;
// line stores are not cleared; depends on lap_pkg, lap_ram, lap_csr and lap_kernel
module laplacian_3x3_rgb_filter import lap_pkg::*; #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_red_in,
   input  logic [7:0]            req_green_in,
   input  logic [7:0]            req_blue_in,
   input  logic                  req_flush,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_red_out,
   output logic [7:0]            rsp_green_out,
   output logic [7:0]            rsp_blue_out,
   output logic                  rsp_frame_last,
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW         = $clog2(MAX_WIDTH);
   localparam int EW         = $clog2(MAX_WIDTH + 1);
   localparam int CW         = $clog2(MAX_WIDTH + 3);
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int OCC_W      = FIFO_CNT_W + 1;

   cfg_type cfg;

   // effective geometry
   logic [EW-1:0]       eff_w;
   logic [AW-1:0]       w_last;
   logic [CW-1:0]       w_ext;
   logic [HEIGHT_W-1:0] eff_h;
   logic [HEIGHT_W-1:0] h_last;

   // position counters and backlog
   logic [AW-1:0]       in_col_ff,  in_col_in;
   logic [HEIGHT_W-1:0] in_row_ff,  in_row_in;
   logic [AW-1:0]       out_col_ff, out_col_in;
   logic [HEIGHT_W-1:0] out_row_ff, out_row_in;
   logic [CW-1:0]       backlog_ff, backlog_in;

   // accept stage
   logic          accept;
   logic          op_valid;
   logic          s0_real;
   logic          s0_emit;
   logic          s0_two;
   logic [AW-1:0] s0_addr;
   logic          at_start;
   logic          out_border;
   logic          out_last;

   // line store stage
   logic          s1_valid_ff,  s1_valid_in;
   logic          s1_real_ff,   s1_real_in;
   logic          s1_emit_ff,   s1_emit_in;
   logic          s1_two_ff,    s1_two_in;
   logic          s1_border_ff, s1_border_in;
   logic          s1_last_ff,   s1_last_in;
   pixel_type     s1_px_ff,     s1_px_in;
   logic [AW-1:0] s1_addr_ff,   s1_addr_in;
   pixel_type     one_rd;
   pixel_type     two_rd;
   pixel_type     mid;
   pixel_type     top;
   logic          wr_en;

   // forwarding of the write made at the edge of the last read
   logic          fw_valid_ff, fw_valid_in;
   logic [AW-1:0] fw_addr_ff,  fw_addr_in;
   pixel_type     fw_one_ff,   fw_one_in;
   pixel_type     fw_two_ff,   fw_two_in;

   // 3x3 window, numbered row by row; only entries read after a shift are held
   pixel_type win2_ff, win2_in;
   pixel_type win4_ff, win4_in;
   pixel_type win5_ff, win5_in;
   pixel_type win8_ff, win8_in;

   // kernel stage
   taps_type   taps;
   logic       res_valid;
   result_type res;

   // output queue
   result_type              fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   cnt_ff,    cnt_in;
   logic [OCC_W-1:0]        occupancy;
   logic                    push;
   logic                    pop;
   result_type              head;

   lap_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // zero reads as one, width clipped to the line store depth
   always_comb begin
      if (cfg.width == '0) begin
         eff_w = EW'(1);
      end else if (32'(cfg.width) > MAX_WIDTH) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = EW'(cfg.width);
      end
      eff_h = (cfg.height == '0) ? HEIGHT_W'(1) : cfg.height;
   end

   assign w_last = AW'(eff_w - EW'(1));
   assign w_ext  = CW'(eff_w);
   assign h_last = eff_h - HEIGHT_W'(1);

   // room for every result already in flight plus one more
   assign occupancy = OCC_W'(cnt_ff) + OCC_W'(s1_emit_ff) + OCC_W'(res_valid);
   assign req_stall = occupancy >= OCC_W'(FIFO_DEPTH);
   assign accept    = req_valid && !req_stall;

   assign at_start   = (in_col_ff == '0) && (in_row_ff == '0);
   assign out_border = (out_row_ff == '0) || (out_row_ff == h_last)
                    || (out_col_ff == '0) || (out_col_ff == w_last);
   assign out_last   = (out_row_ff == h_last) && (out_col_ff == w_last);

   // accept stage: all control is settled here, data is registered into the line store stage
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      backlog_in = backlog_ff;
      op_valid   = 1'b0;
      s0_real    = 1'b0;
      s0_emit    = 1'b0;
      s0_two     = 1'b0;
      s0_addr    = in_col_ff;
      if (accept) begin
         if (!req_flush) begin
            // real pixel: goes into the line stores, may release the oldest pending one
            op_valid = 1'b1;
            s0_real  = 1'b1;
            if (in_col_ff == w_last) begin
               in_col_in = '0;
               in_row_in = (in_row_ff == h_last) ? '0 : in_row_ff + HEIGHT_W'(1);
            end else begin
               in_col_in = in_col_ff + AW'(1);
            end
            if (backlog_ff > w_ext) begin
               s0_emit = 1'b1;
            end else begin
               backlog_in = backlog_ff + CW'(1);
            end
         end else if (at_start && (backlog_ff != '0)) begin
            // flush at frame start: oldest pending pixel straight from a line store
            op_valid   = 1'b1;
            s0_emit    = 1'b1;
            s0_addr    = out_col_ff;
            s0_two     = backlog_ff > w_ext;
            backlog_in = backlog_ff - CW'(1);
         end
         if (s0_emit) begin
            if (out_col_ff == w_last) begin
               out_col_in = '0;
               out_row_in = (out_row_ff == h_last) ? '0 : out_row_ff + HEIGHT_W'(1);
            end else begin
               out_col_in = out_col_ff + AW'(1);
            end
         end
      end
      if (cfg.restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         backlog_in = '0;
      end
   end

   assign s1_valid_in  = op_valid;
   assign s1_real_in   = s0_real;
   assign s1_emit_in   = s0_emit;
   assign s1_two_in    = s0_two;
   assign s1_border_in = out_border;
   assign s1_last_in   = out_last;
   assign s1_px_in     = {req_blue_in, req_green_in, req_red_in};
   assign s1_addr_in   = s0_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         backlog_ff  <= '0;
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
         fw_valid_ff <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         backlog_ff  <= backlog_in;
         s1_valid_ff <= s1_valid_in;
         s1_emit_ff  <= s1_emit_in;
         fw_valid_ff <= fw_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_real_ff   <= s1_real_in;
      s1_two_ff    <= s1_two_in;
      s1_border_ff <= s1_border_in;
      s1_last_ff   <= s1_last_in;
      s1_px_ff     <= s1_px_in;
      s1_addr_ff   <= s1_addr_in;
      fw_addr_ff   <= fw_addr_in;
      fw_one_ff    <= fw_one_in;
      fw_two_ff    <= fw_two_in;
   end

   // line stores: one row up and two rows up, indexed by column
   assign wr_en = s1_valid_ff && s1_real_ff;

   lap_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_one (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_px_ff),
      .rd_en   (op_valid),
      .rd_addr (s0_addr),
      .rd_data (one_rd)
   );

   lap_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_two (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (mid),
      .rd_en   (op_valid),
      .rd_addr (s0_addr),
      .rd_data (two_rd)
   );

   // a read issued on the edge of a write to the same column sees the old entry
   assign mid = (fw_valid_ff && (fw_addr_ff == s1_addr_ff)) ? fw_one_ff : one_rd;
   assign top = (fw_valid_ff && (fw_addr_ff == s1_addr_ff)) ? fw_two_ff : two_rd;

   assign fw_valid_in = wr_en;
   assign fw_addr_in  = s1_addr_ff;
   assign fw_one_in   = s1_px_ff;
   assign fw_two_in   = mid;

   // window shift on every real pixel
   always_comb begin
      win2_in = win2_ff;
      win4_in = win4_ff;
      win5_in = win5_ff;
      win8_in = win8_ff;
      if (wr_en) begin
         win2_in = top;
         win4_in = win5_ff;
         win5_in = mid;
         win8_in = s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      win2_ff <= win2_in;
      win4_ff <= win4_in;
      win5_ff <= win5_in;
      win8_ff <= win8_in;
   end

   // neighbourhood after the shift, or a flushed pixel passed straight on
   always_comb begin
      taps.last  = s1_last_ff;
      taps.north = win2_ff;
      taps.west  = win4_ff;
      taps.east  = mid;
      taps.south = win8_ff;
      if (s1_real_ff) begin
         taps.border = s1_border_ff;
         taps.center = win5_ff;
      end else begin
         taps.border = 1'b1;
         taps.center = s1_two_ff ? top : mid;
      end
   end

   lap_kernel u_kernel (
      .clock     (clock),
      .reset     (reset),
      .mode      (cfg.mode),
      .tap_valid (s1_emit_ff),
      .taps      (taps),
      .res_valid (res_valid),
      .res       (res)
   );

   // output queue decouples the pipeline from a stalled receiver
   assign push = res_valid;
   assign pop  = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= res;
      end
   end

   assign head           = fifo_ff[rd_ptr_ff];
   assign rsp_valid      = cnt_ff != '0;
   assign rsp_red_out    = head.pixel[7:0];
   assign rsp_green_out  = head.pixel[15:8];
   assign rsp_blue_out   = head.pixel[23:16];
   assign rsp_frame_last = head.last;

`ifndef NO_ASSERTIONS
   // pending pixels never exceed one row plus one
   a_backlog_bound: assert property (@(posedge clock) disable iff (reset)
      backlog_ff <= w_ext + CW'(1))
      else $error("backlog above width plus one");

   // a flushed pixel is only released while the input stands at frame start
   a_flush_at_start: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_real_ff) |-> (in_col_ff == '0 && in_row_ff == '0))
      else $error("flush release away from frame start");

   // the stall accounting keeps a slot free for every kernel result
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (cnt_ff < FIFO_CNT_W'(FIFO_DEPTH)))
      else $error("kernel result into full output queue");

   // a released pixel reaches the kernel stage in the next cycle
   a_emit_flow: assert property (@(posedge clock) disable iff (reset)
      s1_emit_ff |=> res_valid)
      else $error("released pixel lost before kernel stage");
`endif

endmodule

FILE: design/lap_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module lap_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic [WIDTH-1:0] rd_data_in;

   // storage array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   assign rd_data_in = mem_ff[rd_addr];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rd_data_in;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/lap_csr.sv
// apb-style register block: mode, image width and image height
// depends on lap_pkg
module lap_csr import lap_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [MODE_W-1:0]      mode_ff,   mode_in;
   logic [WIDTH_REG_W-1:0] width_ff,  width_in;
   logic [HEIGHT_W-1:0]    height_ff, height_in;
   logic                   wr_stb;
   logic                   restart;
   logic [REG_IDX_W-1:0]   idx;

   assign pready = 1'b1;
   assign wr_stb = psel && penable && pwrite;
   assign idx    = paddr[CSR_ADDR_W-1:2];

   // write decode
   always_comb begin
      mode_in   = mode_ff;
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (wr_stb) begin
         unique case (idx)
            REG_MODE: begin
               mode_in = pwdata[MODE_W-1:0];
            end
            REG_WIDTH: begin
               width_in = pwdata[WIDTH_REG_W-1:0];
               restart  = 1'b1;
            end
            REG_HEIGHT: begin
               height_in = pwdata[HEIGHT_W-1:0];
               restart   = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_TRUNC;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         mode_ff   <= mode_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         REG_MODE:   prdata = CSR_DATA_W'(mode_ff);
         REG_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         default:    prdata = '0;
      endcase
   end

   // restart takes effect at the edge of the geometry write
   assign cfg.mode    = mode_ff;
   assign cfg.width   = width_ff;
   assign cfg.height  = height_ff;
   assign cfg.restart = restart;

endmodule

FILE: design/lap_kernel.sv
// kernel stage: registers the neighbourhood, applies the 4-neighbour laplacian
// per colour channel and the selected post-processing mode
// depends on lap_pkg
module lap_kernel import lap_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [MODE_W-1:0] mode,
   input  logic              tap_valid,
   input  taps_type          taps,
   output logic              res_valid,
   output result_type        res
);

   logic     valid_ff, valid_in;
   taps_type taps_ff,  taps_in;

   // one colour channel: laplacian sum then post-processing
   function automatic logic [7:0] post_chan(
      input logic [MODE_W-1:0] md,
      input logic [7:0]        c,
      input logic [7:0]        n,
      input logic [7:0]        w,
      input logic [7:0]        e,
      input logic [7:0]        s
   );
      logic signed [11:0] sum;
      logic signed [11:0] adj;
      logic signed [11:0] quo;
      logic [7:0]         r;
      sum = $signed({2'b00, c, 2'b00}) - $signed({4'b0000, n}) - $signed({4'b0000, w})
          - $signed({4'b0000, e}) - $signed({4'b0000, s});
      adj = '0;
      quo = '0;
      r   = '0;
      case (md)
         MODE_TRUNC: begin
            r = sum[7:0];
         end
         MODE_CENTER: begin
            adj = sum + 12'sd128;
            if (adj < 12'sd0) begin
               r = 8'h00;
            end else if (adj > 12'sd255) begin
               r = 8'hFF;
            end else begin
               r = adj[7:0];
            end
         end
         MODE_MAG: begin
            adj = (sum < 12'sd0) ? -sum : sum;
            r   = (adj > 12'sd255) ? 8'hFF : adj[7:0];
         end
         MODE_SCALE: begin
            // divide by eight rounding toward zero
            adj = (sum < 12'sd0) ? sum + 12'sd7 : sum;
            quo = adj >>> 3;
            r   = quo[7:0] + 8'd128;
         end
         default: begin
            r = sum[7:0];
         end
      endcase
      return r;
   endfunction

   assign valid_in = tap_valid;
   assign taps_in  = taps;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      taps_ff <= taps_in;
   end

   // border pixels pass through, interior pixels are filtered
   always_comb begin
      res.last = taps_ff.last;
      if (taps_ff.border) begin
         res.pixel = taps_ff.center;
      end else begin
         res.pixel[7:0]   = post_chan(mode, taps_ff.center[7:0], taps_ff.north[7:0],
                                      taps_ff.west[7:0], taps_ff.east[7:0],
                                      taps_ff.south[7:0]);
         res.pixel[15:8]  = post_chan(mode, taps_ff.center[15:8], taps_ff.north[15:8],
                                      taps_ff.west[15:8], taps_ff.east[15:8],
                                      taps_ff.south[15:8]);
         res.pixel[23:16] = post_chan(mode, taps_ff.center[23:16], taps_ff.north[23:16],
                                      taps_ff.west[23:16], taps_ff.east[23:16],
                                      taps_ff.south[23:16]);
      end
   end

   assign res_valid = valid_ff;

endmodule
